[rtl/pma_pkg.sv]
// Shared types, constants and helper function of the penalized moment accumulator.
package pma_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int OCC_W  = 18;
    localparam int AREA_W = 31;
    localparam int CRD_W  = 32;
    localparam int SUM_W  = 64;

    localparam int MUL_W      = 64;
    localparam int DIGIT_W    = 16;
    localparam int NUM_DIGITS = MUL_W / DIGIT_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_AREA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 2'd2;

    localparam logic signed [SUM_W-1:0] SAT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int OP_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_AD,
        OP_F,
        OP_DXX,
        OP_DYY,
        OP_DXV,
        OP_DYU,
        OP_FR2,
        OP_FDX,
        OP_FDY,
        OP_FU,
        OP_FV,
        OP_FCR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic signed [OCC_W-1:0] occupancy;
        logic [AREA_W-1:0]       density;
        logic signed [CRD_W-1:0] u_here;
        logic signed [CRD_W-1:0] u_right;
        logic signed [CRD_W-1:0] v_here;
        logic signed [CRD_W-1:0] v_up;
        logic signed [CRD_W-1:0] pos_x;
        logic signed [CRD_W-1:0] pos_y;
        logic                    last_cell;
    } cell_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] penal_mass;
        logic signed [SUM_W-1:0] penal_inertia;
        logic signed [SUM_W-1:0] penal_moment_x;
        logic signed [SUM_W-1:0] penal_moment_y;
        logic signed [SUM_W-1:0] fluid_momentum_x;
        logic signed [SUM_W-1:0] fluid_momentum_y;
        logic signed [SUM_W-1:0] fluid_angular_momentum;
    } sum_word_t;

    typedef struct packed {
        logic                    start;
        logic signed [MUL_W-1:0] mcand;
        logic signed [MUL_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic en;
        logic clear;
        op_t  op;
    } wb_cmd_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] t1;
        logic signed [SUM_W-1:0] f;
        logic signed [SUM_W-1:0] r2;
        logic signed [SUM_W-1:0] cr;
    } opnd_t;

    function automatic logic signed [SUM_W-1:0] sat_addsub(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b,
        input logic                    sub
    );
        logic [SUM_W:0] s;
        if (sub)
        begin
            s = {a[SUM_W-1], a} - {b[SUM_W-1], b};
        end
        else
        begin
            s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        end
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? SAT_MIN : SAT_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

[rtl/pma_mul.sv]
// Shared digit-serial fixed-point multiplier with floor scaling and 64-bit saturation.
module pma_mul
    import pma_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int PP_W     = MUL_W + DIGIT_W;
    localparam int SHIFT_UP = PROD_W - PP_W;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [MUL_W-1:0]        mcand_reg;
    logic [MUL_W-1:0]        dig_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] res_reg;

    logic [MUL_W-1:0]        a_mag;
    logic [MUL_W-1:0]        b_mag;
    logic [PP_W-1:0]         pp;
    logic [PROD_W-1:0]       prod_step;
    logic [PROD_W-1:0]       aligned;
    logic [PROD_W-1:0]       quot;
    logic                    sticky;
    logic                    hi_nz;
    logic [MUL_W:0]          mag_inc;
    logic signed [SUM_W-1:0] res_next;

    assign a_mag = req.mcand[MUL_W-1] ? (~req.mcand + 1'b1) : req.mcand;
    assign b_mag = req.mplier[MUL_W-1] ? (~req.mplier + 1'b1) : req.mplier;

    assign pp        = PP_W'(mcand_reg) * PP_W'(dig_reg[DIGIT_W-1:0]);
    assign prod_step = (prod_reg >> DIGIT_W) + (PROD_W'(pp) << SHIFT_UP);

    always_comb
    begin
        aligned = '0;
        for (int k = 0; k <= NUM_DIGITS; k++)
        begin
            if (cnt_reg == CNT_W'(k))
            begin
                aligned = prod_reg >> (DIGIT_W * (NUM_DIGITS - k));
            end
        end
    end

    assign quot    = aligned >> FRAC_BITS;
    assign sticky  = |aligned[FRAC_BITS-1:0];
    assign hi_nz   = |quot[PROD_W-1:MUL_W];
    assign mag_inc = {1'b0, quot[MUL_W-1:0]} + (MUL_W+1)'(neg_reg & sticky);

    always_comb
    begin
        if (!neg_reg)
        begin
            res_next = (hi_nz || quot[MUL_W-1]) ? SAT_MAX : quot[MUL_W-1:0];
        end
        else if (hi_nz || mag_inc[MUL_W] || mag_inc[MUL_W-1])
        begin
            res_next = SAT_MIN;
        end
        else
        begin
            res_next = -mag_inc[MUL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && dig_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg <= a_mag;
            dig_reg   <= b_mag;
            prod_reg  <= '0;
            cnt_reg   <= '0;
            neg_reg   <= req.mcand[MUL_W-1] ^ req.mplier[MUL_W-1];
        end
        else if (busy_reg)
        begin
            if (dig_reg != '0)
            begin
                prod_reg <= prod_step;
                dig_reg  <= dig_reg >> DIGIT_W;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            else
            begin
                res_reg <= res_next;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

[rtl/pma_acc.sv]
// Intermediate operand registers and the seven saturating moment accumulators.
module pma_acc
    import pma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wb_cmd_t                 wb,
    input  logic signed [SUM_W-1:0] result,
    output opnd_t                   opnd,
    output sum_word_t               sums
);

    logic signed [SUM_W-1:0] t1_reg;
    logic signed [SUM_W-1:0] f_reg;
    logic signed [SUM_W-1:0] r2_reg;
    logic signed [SUM_W-1:0] cr_reg;

    logic signed [SUM_W-1:0] mass_reg;
    logic signed [SUM_W-1:0] inertia_reg;
    logic signed [SUM_W-1:0] first_x_reg;
    logic signed [SUM_W-1:0] first_y_reg;
    logic signed [SUM_W-1:0] mom_x_reg;
    logic signed [SUM_W-1:0] mom_y_reg;
    logic signed [SUM_W-1:0] angular_reg;

    logic signed [SUM_W-1:0] add_a;
    logic signed [SUM_W-1:0] add_sum;

    always_comb
    begin
        unique case (wb.op)
            OP_F:    add_a = mass_reg;
            OP_FR2:  add_a = inertia_reg;
            OP_FDX:  add_a = first_x_reg;
            OP_FDY:  add_a = first_y_reg;
            OP_FU:   add_a = mom_x_reg;
            OP_FV:   add_a = mom_y_reg;
            OP_FCR:  add_a = angular_reg;
            default: add_a = t1_reg;
        endcase
    end

    assign add_sum = sat_addsub(add_a, result, wb.op == OP_DYU);

    always_ff @(posedge clk)
    begin
        if (wb.en)
        begin
            unique case (wb.op)
                OP_AD, OP_DXX, OP_DXV: t1_reg <= result;
                OP_F:                  f_reg  <= result;
                OP_DYY:                r2_reg <= add_sum;
                OP_DYU:                cr_reg <= add_sum;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg    <= '0;
            inertia_reg <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            mom_x_reg   <= '0;
            mom_y_reg   <= '0;
            angular_reg <= '0;
        end
        else if (wb.clear)
        begin
            mass_reg    <= '0;
            inertia_reg <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            mom_x_reg   <= '0;
            mom_y_reg   <= '0;
            angular_reg <= '0;
        end
        else if (wb.en)
        begin
            unique case (wb.op)
                OP_F:    mass_reg    <= add_sum;
                OP_FR2:  inertia_reg <= add_sum;
                OP_FDX:  first_x_reg <= add_sum;
                OP_FDY:  first_y_reg <= add_sum;
                OP_FU:   mom_x_reg   <= add_sum;
                OP_FV:   mom_y_reg   <= add_sum;
                OP_FCR:  angular_reg <= add_sum;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        opnd.t1 = t1_reg;
        opnd.f  = f_reg;
        opnd.r2 = r2_reg;
        opnd.cr = cr_reg;

        sums.penal_mass             = mass_reg;
        sums.penal_inertia          = inertia_reg;
        sums.penal_moment_x         = first_x_reg;
        sums.penal_moment_y         = first_y_reg;
        sums.fluid_momentum_x       = mom_x_reg;
        sums.fluid_momentum_y       = mom_y_reg;
        sums.fluid_angular_momentum = angular_reg;
    end

endmodule

[rtl/penalized_moment_accumulator.sv]
// Top level: configuration registers, cell sequencer and result word register.
// A cell with occupancy zero or below is taken and adds nothing.
// An occupied cell runs twelve products through the one shared 64x16 multiplier; each product
// steps through the 16-bit digits of its second operand until the remaining digits are zero.
// A last cell then passes through the emit state, which moves the sums into the output word register.
// Reset clears the accumulators, sets cell_area to one and the center to zero.
module penalized_moment_accumulator
    import pma_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  cell_valid,
    output logic                  cell_ready,
    input  cell_word_t            cell_word,
    output logic                  sum_valid,
    input  logic                  sum_ready,
    output sum_word_t             sum_word
);

    logic [AREA_W-1:0]       cell_area_reg;
    logic signed [CRD_W-1:0] center_x_reg;
    logic signed [CRD_W-1:0] center_y_reg;

    seq_state_t state_reg;
    seq_state_t state_next;
    op_t        op_reg;
    op_t        op_next;

    logic signed [OCC_W-1:0] occ_reg;
    logic [AREA_W-1:0]       dens_reg;
    logic signed [CRD_W:0]   dx_reg;
    logic signed [CRD_W:0]   dy_reg;
    logic signed [CRD_W-1:0] uu_reg;
    logic signed [CRD_W-1:0] vv_reg;
    logic                    last_reg;

    logic       sum_valid_reg;
    sum_word_t  sum_word_reg;

    logic       accept;
    logic       occupied;
    logic       issue;
    logic       emit;
    logic [CRD_W:0] u_sum;
    logic [CRD_W:0] v_sum;

    mul_req_t  req;
    mul_rsp_t  rsp;
    wb_cmd_t   wb;
    opnd_t     opnd;
    sum_word_t sums;

    assign accept   = cell_valid && cell_ready;
    assign occupied = !cell_word.occupancy[OCC_W-1] && (cell_word.occupancy != '0);
    assign u_sum    = {cell_word.u_here[CRD_W-1], cell_word.u_here}
                    + {cell_word.u_right[CRD_W-1], cell_word.u_right};
    assign v_sum    = {cell_word.v_here[CRD_W-1], cell_word.v_here}
                    + {cell_word.v_up[CRD_W-1], cell_word.v_up};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_area_reg <= AREA_W'(1) << FRAC_BITS;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_AREA: cell_area_reg <= cfg_wdata[AREA_W-1:0];
                REG_CENTER_X:  center_x_reg  <= cfg_wdata[CRD_W-1:0];
                REG_CENTER_Y:  center_y_reg  <= cfg_wdata[CRD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_AD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cell_ready = 1'b0;
        issue      = 1'b0;
        emit       = 1'b0;
        wb.en      = 1'b0;
        wb.clear   = 1'b0;
        wb.op      = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cell_ready = 1'b1;
                if (cell_valid)
                begin
                    op_next = OP_AD;
                    if (occupied)
                    begin
                        state_next = ST_ISSUE;
                    end
                    else if (cell_word.last_cell)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ISSUE:
            begin
                issue      = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (rsp.done)
                begin
                    wb.en = 1'b1;
                    if (op_reg == OP_FCR)
                    begin
                        state_next = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        op_next    = op_t'(OP_W'(op_reg) + OP_W'(1));
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!sum_valid_reg || sum_ready)
                begin
                    emit       = 1'b1;
                    wb.clear   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.start  = issue;
        req.mcand  = '0;
        req.mplier = '0;
        unique case (op_reg)
            OP_AD:
            begin
                req.mcand  = MUL_W'(cell_area_reg);
                req.mplier = MUL_W'(dens_reg);
            end
            OP_F:
            begin
                req.mcand  = opnd.t1;
                req.mplier = MUL_W'(occ_reg);
            end
            OP_DXX:
            begin
                req.mcand  = MUL_W'(dx_reg);
                req.mplier = MUL_W'(dx_reg);
            end
            OP_DYY:
            begin
                req.mcand  = MUL_W'(dy_reg);
                req.mplier = MUL_W'(dy_reg);
            end
            OP_DXV:
            begin
                req.mcand  = MUL_W'(vv_reg);
                req.mplier = MUL_W'(dx_reg);
            end
            OP_DYU:
            begin
                req.mcand  = MUL_W'(uu_reg);
                req.mplier = MUL_W'(dy_reg);
            end
            OP_FR2:
            begin
                req.mcand  = opnd.r2;
                req.mplier = opnd.f;
            end
            OP_FDX:
            begin
                req.mcand  = opnd.f;
                req.mplier = MUL_W'(dx_reg);
            end
            OP_FDY:
            begin
                req.mcand  = opnd.f;
                req.mplier = MUL_W'(dy_reg);
            end
            OP_FU:
            begin
                req.mcand  = opnd.f;
                req.mplier = MUL_W'(uu_reg);
            end
            OP_FV:
            begin
                req.mcand  = opnd.f;
                req.mplier = MUL_W'(vv_reg);
            end
            OP_FCR:
            begin
                req.mcand  = opnd.cr;
                req.mplier = opnd.f;
            end
            default:
            begin
                req.mcand  = '0;
                req.mplier = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            occ_reg  <= cell_word.occupancy;
            dens_reg <= cell_word.density;
            dx_reg   <= {cell_word.pos_x[CRD_W-1], cell_word.pos_x}
                      - {center_x_reg[CRD_W-1], center_x_reg};
            dy_reg   <= {cell_word.pos_y[CRD_W-1], cell_word.pos_y}
                      - {center_y_reg[CRD_W-1], center_y_reg};
            uu_reg   <= u_sum[CRD_W:1];
            vv_reg   <= v_sum[CRD_W:1];
            last_reg <= cell_word.last_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            sum_valid_reg <= 1'b1;
        end
        else if (sum_ready)
        begin
            sum_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sum_word_reg <= sums;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_word  = sum_word_reg;

    pma_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    pma_acc u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .wb     (wb),
        .result (rsp.result),
        .opnd   (opnd),
        .sums   (sums)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for the penalized moment accumulator: moment scoreboard, cell drivers and top module.
module tb
    import pma_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES = 2000;
    localparam int CYCLE_LIMIT = 1000000;

    class moment_board;
        logic [AREA_W-1:0] area;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic signed [SUM_W-1:0] mass, inertia, first_x, first_y, mom_x, mom_y, angular;
        sum_word_t sums_due[$];
        int errors;
        string tag[7] = '{"penal_mass", "penal_inertia", "penal_moment_x", "penal_moment_y",
                          "fluid_momentum_x", "fluid_momentum_y", "fluid_angular_momentum"};

        function new();
            area = AREA_W'(1) << FRAC_BITS_DEF;
            cx = 0;
            cy = 0;
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            mass = 0;
            inertia = 0;
            first_x = 0;
            first_y = 0;
            mom_x = 0;
            mom_y = 0;
            angular = 0;
        endfunction

        function logic signed [SUM_W-1:0] clamp64(logic signed [127:0] x);
            logic signed [127:0] top, bot;
            top = SAT_MAX;
            bot = SAT_MIN;
            if (x > top)
            begin
                return SAT_MAX;
            end
            if (x < bot)
            begin
                return SAT_MIN;
            end
            return x[SUM_W-1:0];
        endfunction

        function logic signed [SUM_W-1:0] qmul(logic signed [SUM_W-1:0] a,
                                               logic signed [SUM_W-1:0] b);
            logic signed [127:0] wa, wb;
            wa = a;
            wb = b;
            return clamp64((wa * wb) >>> FRAC_BITS_DEF);
        endfunction

        function logic signed [SUM_W-1:0] qsum(logic signed [SUM_W-1:0] a,
                                               logic signed [SUM_W-1:0] b, bit sub);
            logic signed [127:0] wa, wb;
            wa = a;
            wb = b;
            return clamp64(sub ? wa - wb : wa + wb);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CELL_AREA: area = data[AREA_W-1:0];
                REG_CENTER_X:  cx = data;
                REG_CENTER_Y:  cy = data;
                default: ;
            endcase
        endfunction

        function void take_cell(cell_word_t c);
            logic signed [SUM_W-1:0] occ, dens, uu, vv, dx, dy, f, r2, cr;
            logic signed [CRD_W:0] su, sv;
            sum_word_t s;
            occ = c.occupancy;
            if (occ > 0)
            begin
                dens = c.density;
                su = c.u_here + c.u_right;
                sv = c.v_here + c.v_up;
                uu = su >>> 1;
                vv = sv >>> 1;
                dx = c.pos_x - cx;
                dy = c.pos_y - cy;
                f = qmul(qmul(area, dens), occ);
                r2 = qsum(qmul(dx, dx), qmul(dy, dy), 1'b0);
                cr = qsum(qmul(dx, vv), qmul(dy, uu), 1'b1);
                mass = qsum(mass, f, 1'b0);
                inertia = qsum(inertia, qmul(f, r2), 1'b0);
                first_x = qsum(first_x, qmul(f, dx), 1'b0);
                first_y = qsum(first_y, qmul(f, dy), 1'b0);
                mom_x = qsum(mom_x, qmul(f, uu), 1'b0);
                mom_y = qsum(mom_y, qmul(f, vv), 1'b0);
                angular = qsum(angular, qmul(f, cr), 1'b0);
            end
            if (c.last_cell)
            begin
                s.penal_mass = mass;
                s.penal_inertia = inertia;
                s.penal_moment_x = first_x;
                s.penal_moment_y = first_y;
                s.fluid_momentum_x = mom_x;
                s.fluid_momentum_y = mom_y;
                s.fluid_angular_momentum = angular;
                sums_due.push_back(s);
                clear_sums();
            end
        endfunction

        function void check_sums(sum_word_t got);
            sum_word_t due;
            logic signed [SUM_W-1:0] want, seen;
            if (sums_due.size() == 0)
            begin
                errors++;
                $display("%0t: sum word with no cell sweep pending", $time);
                return;
            end
            due = sums_due.pop_front();
            for (int i = 0; i < 7; i++)
            begin
                want = due[(6 - i) * SUM_W +: SUM_W];
                seen = got[(6 - i) * SUM_W +: SUM_W];
                if (want !== seen)
                begin
                    errors++;
                    $display("%0t: %s expected %0d got %0d", $time, tag[i], want, seen);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic cell_valid;
    logic cell_ready;
    cell_word_t cell_word;
    logic sum_valid;
    logic sum_ready;
    sum_word_t sum_word;

    moment_board board;
    int send_idle;
    int recv_stall;
    bit hold_on;
    int hold_count;
    int cycle_count;

    penalized_moment_accumulator DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cell_valid(cell_valid),
        .cell_ready(cell_ready),
        .cell_word(cell_word),
        .sum_valid(sum_valid),
        .sum_ready(sum_ready),
        .sum_word(sum_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("penalized_moment_accumulator: mismatch");
        $finish;
    end

    initial
    begin
        sum_ready <= 1'b0;
        hold_count = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && sum_valid && sum_ready)
            begin
                board.check_sums(sum_word);
            end
            if (hold_on && hold_count < HOLD_CYCLES)
            begin
                hold_count++;
                sum_ready <= 1'b0;
            end
            else
            begin
                sum_ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    function automatic logic [31:0] coord();
        if ($urandom_range(3) == 0)
        begin
            return $urandom;
        end
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    function automatic cell_word_t make_cell(input logic [OCC_W-1:0] occ,
                                             input logic [AREA_W-1:0] dens,
                                             input logic [31:0] uh, ur, vh, vu, px, py,
                                             input bit last);
        cell_word_t c;
        c.occupancy = occ;
        c.density = dens;
        c.u_here = uh;
        c.u_right = ur;
        c.v_here = vh;
        c.v_up = vu;
        c.pos_x = px;
        c.pos_y = py;
        c.last_cell = last;
        return c;
    endfunction

    function automatic cell_word_t random_cell(input bit last, input bit noise);
        cell_word_t c;
        int pick;
        pick = $urandom_range(9);
        if (noise || pick == 0)
        begin
            c.occupancy = OCC_W'($urandom);
        end
        else if (pick == 1)
        begin
            c.occupancy = OCC_W'(-$urandom_range(0, 65536));
        end
        else
        begin
            c.occupancy = OCC_W'($urandom_range(1, 65536));
        end
        c.density = AREA_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4 << 16));
        c.u_here = coord();
        c.u_right = coord();
        c.v_here = coord();
        c.v_up = coord();
        c.pos_x = coord();
        c.pos_y = coord();
        c.last_cell = last;
        return c;
    endfunction

    task automatic send_cell(input cell_word_t c);
        while ($urandom_range(99) < send_idle)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_word <= c;
        do
            @(posedge clk);
        while (!cell_ready);
        board.take_cell(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
    endtask

    task automatic settle();
        while (board.sums_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic sweep(input int n_cells);
        int sent;
        int len;
        bit noise;
        sent = 0;
        while (sent < n_cells)
        begin
            noise = ($urandom_range(7) == 0);
            len = $urandom_range(1, 10);
            for (int k = 0; k < len && sent < n_cells; k++)
            begin
                send_cell(random_cell(noise ? bit'($urandom_range(1)) : (k == len - 1), noise));
                sent++;
            end
        end
        cell_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] area, cxv, cyv, input int idle_pct, stall_pct,
                             input int n_cells, input bit squeeze);
        settle();
        write_reg(REG_CELL_AREA, area);
        write_reg(REG_CENTER_X, cxv);
        write_reg(REG_CENTER_Y, cyv);
        if ($urandom_range(1))
        begin
            write_reg(REG_NONE, $urandom);
        end
        send_idle = idle_pct;
        recv_stall = stall_pct;
        hold_on = squeeze;
        sweep(n_cells);
    endtask

    task automatic directed();
        send_cell(make_cell(18'h10000, 31'h10000, 32'h10000, 32'h30000, 32'hFFFF0000,
                            32'h10000, 32'h20000, 32'hFFFF0000, 1'b1));
        send_cell(make_cell(18'h0, 31'h10000, 32'h10000, 32'h10000, 32'h10000,
                            32'h10000, 32'h10000, 32'h10000, 1'b1));
        send_cell(make_cell(18'h20000, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
        send_cell(make_cell(18'h10000, 31'h20000, 32'h8000, 32'h18000, 32'h4000,
                            32'hFFFFC000, 32'h30000, 32'h50000, 1'b0));
        send_cell(make_cell(18'h1, 31'h1, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 1'b0));
        send_cell(make_cell(18'h08000, 31'h10000, 32'hFFFE0000, 32'h10000, 32'h20000,
                            32'h0, 32'hFFFF0000, 32'h10000, 1'b1));
        send_cell(make_cell(18'h1FFFF, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
        send_cell(make_cell(18'h1FFFF, 31'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
        send_cell(make_cell(18'h10000, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1));
        send_cell(make_cell(18'h10000, 31'h0, 32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9,
                            32'h87654321, 32'h55555555, 32'hAAAAAAAA, 1'b1));
        send_cell(make_cell(18'h10000, 31'h10000, 32'h1, 32'h0, 32'hFFFFFFFF,
                            32'h0, 32'h3, 32'hFFFFFFFD, 1'b1));
        send_cell(make_cell(18'h1FFFF, 31'h7FFFFFFF, 32'h0, 32'h0, 32'h0,
                            32'h0, 32'h7FFFFFFF, 32'h0, 1'b0));
        send_cell(make_cell(18'h1FFFF, 31'h7FFFFFFF, 32'h0, 32'h0, 32'h0,
                            32'h0, 32'h7FFFFFFF, 32'h0, 1'b1));
        send_cell(make_cell(18'h20000, 31'h0, 32'h0, 32'h0, 32'h0,
                            32'h0, 32'h0, 32'h0, 1'b1));
        cell_valid <= 1'b0;
    endtask

    initial
    begin
        int idle_pick;
        board = new();
        send_idle = 0;
        recv_stall = 0;
        hold_on = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_CELL_AREA;
        cfg_wdata <= '0;
        cell_valid <= 1'b0;
        cell_word <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        run_phase(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 47, 0, 140, 1'b0);
        run_phase(32'h0, 32'h7FFFFFFF, 32'h80000000, 0, 47, 100, 1'b1);
        run_phase(32'h80010000, coord(), coord(), 35, 35, 150, 1'b0);
        hold_on = 1'b0;
        for (int p = 0; p < 3; p++)
        begin
            idle_pick = $urandom_range(3);
            run_phase(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4 << 16),
                      coord(), coord(),
                      (idle_pick == 1) ? 47 : (idle_pick == 3) ? 35 : 0,
                      (idle_pick == 2) ? 47 : (idle_pick == 3) ? 35 : 0,
                      150, 1'b0);
        end
        settle();
        if (board.errors == 0)
        begin
            $display("penalized_moment_accumulator: match");
        end
        else
        begin
            $display("penalized_moment_accumulator: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/pma_pkg.sv
rtl/pma_mul.sv
rtl/pma_acc.sv
rtl/penalized_moment_accumulator.sv
sim/tb.sv
